// File: src/arp_pkg.sv
// Package: shared constants for the ARP resolver cache.
package arp_pkg;
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam logic [3:0] ST_REPLY    = 4'd0;
  localparam logic [3:0] ST_NEWREQ   = 4'd1;
  localparam logic [3:0] ST_LEARNED  = 4'd2;
  localparam logic [3:0] ST_RESOLVED = 4'd3;
  localparam logic [3:0] ST_PENDING  = 4'd4;
  localparam logic [3:0] ST_INVALID  = 4'd5;
  localparam logic [3:0] ST_NOTOURS  = 4'd6;
  localparam logic [3:0] ST_UNREQ    = 4'd7;
  localparam logic [3:0] ST_UNKNOWN  = 4'd8;
  localparam logic [3:0] ST_FLUSHED  = 4'd9;
  localparam logic [3:0] ST_RETX     = 4'd10;
  localparam logic [1:0] FN_HEADER  = 2'd0;
  localparam logic [1:0] FN_RESOLVE = 2'd1;
  localparam logic [1:0] FN_TICK    = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_REQ  = 2'd1;
  localparam logic [1:0] OP_REP  = 2'd2;
  localparam logic       CFG_LOCAL_IP  = 1'b0;
  localparam logic       CFG_LOCAL_MAC = 1'b1;
  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
endpackage

// File: src/arp_resolver_cache.sv
// Top level: ARP header check, table lookup and retransmit sequencer.
//
// Channel  Direction  Handshake               Payload
// in_      input      start & !busy           func, header fields, lookup_ip
// out_     output     out_strobe, one cycle   status, send fields, found_mac, last
// cfg_     input      cfg_valid & cfg_ready   cfg_index, cfg_data
//
// Some items are answered at once. Others scan the table one entry a cycle
// through a single 32-bit compare; a resolve does a hit scan, then an
// empty-slot scan. Each result leaves in the cycle after the cycle that
// decides it. A flush clears the other valid bits at once and reuses slot 0.
// Reset is synchronous and clears the table valid bits and control state.
// Results cannot be stalled; busy holds during work.
module arp_resolver_cache #(
  parameter int TABLE_ENTRIES = arp_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_arp_opcode,
  input  logic [15:0] in_hw_type,
  input  logic [15:0] in_proto_type,
  input  logic [7:0]  in_hw_len,
  input  logic [7:0]  in_proto_len,
  input  logic [31:0] in_sender_ip,
  input  logic [47:0] in_sender_mac,
  input  logic [31:0] in_target_ip,
  input  logic [31:0] in_lookup_ip,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data,
  output logic        out_strobe,
  output logic [3:0]  out_status,
  output logic        out_send_packet,
  output logic [1:0]  out_send_opcode,
  output logic [47:0] out_send_dest_mac,
  output logic [47:0] out_send_target_mac,
  output logic [31:0] out_send_target_ip,
  output logic [47:0] out_found_mac,
  output logic        out_last
);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST_IDX = CW'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HIT   = 3'd1;
  localparam logic [2:0] S_EMPTY = 3'd2;
  localparam logic [2:0] S_TICK  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_LEARN = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [31:0] local_ip_r;
  logic [47:0] local_mac_r;
  logic [31:0] key_r;
  logic [47:0] smac_r;
  logic        learn_r;
  logic        pend_r, pend_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic        armed_r, armed_nxt;
  logic [31:0] addr_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] used_r, ready_r;
  logic [IW-1:0] cur;
  logic [31:0] cur_addr;
  logic        match, is_last;

  logic        we;
  logic [IW-1:0] waddr, raddr;
  logic [47:0] rdata;

  arp_ram #(.WIDTH(48), .DEPTH(TABLE_ENTRIES)) u_mac (
    .clk(clk), .we(we), .waddr(waddr), .wdata(smac_r),
    .raddr(raddr), .rdata(rdata)
  );

  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign busy = (state_r != S_IDLE);
  assign cur = idx_r[IW-1:0];
  assign cur_addr = used_r[cur] ? addr_r[cur] : 32'd0;
  assign match = (cur_addr == key_r);
  assign is_last = (idx_r == LAST_IDX);
  assign raddr = cur;
  assign we = (state_r == S_LEARN);
  assign waddr = cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0;
      local_mac_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == arp_pkg::CFG_LOCAL_IP) begin
        local_ip_r <= cfg_data[31:0];
      end else begin
        local_mac_r <= cfg_data;
      end
    end
  end

  logic        o_stb;
  logic [3:0]  o_st;
  logic [1:0]  o_op;
  logic [31:0] o_ip;
  logic [47:0] o_mac, o_found;
  logic        o_last;
  logic        set_entry, flush, mark_ready;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    pend_nxt = pend_r;
    n_nxt = n_r;
    armed_nxt = armed_r;
    o_stb = 1'b0;
    o_st = arp_pkg::ST_INVALID;
    o_op = arp_pkg::OP_NONE;
    o_ip = '0;
    o_mac = '0;
    o_found = '0;
    o_last = 1'b1;
    set_entry = 1'b0;
    flush = 1'b0;
    mark_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          idx_nxt = '0;
          case (in_func)
            arp_pkg::FN_HEADER: begin
              if (in_arp_opcode != 16'd1 && in_arp_opcode != 16'd2) begin
                o_stb = 1'b1; o_st = arp_pkg::ST_UNKNOWN;
              end else if (in_hw_type != 16'd1 || in_proto_type != 16'h0800 ||
                           in_hw_len != 8'd6 || in_proto_len != 8'd4) begin
                o_stb = 1'b1; o_st = arp_pkg::ST_INVALID;
              end else if (in_target_ip != local_ip_r) begin
                o_stb = 1'b1; o_st = arp_pkg::ST_NOTOURS;
              end else if (in_arp_opcode == 16'd1) begin
                o_stb = 1'b1; o_st = arp_pkg::ST_REPLY; o_op = arp_pkg::OP_REP;
                o_ip = in_sender_ip; o_mac = in_sender_mac;
              end else if (in_sender_ip == 32'd0) begin
                o_stb = 1'b1; o_st = arp_pkg::ST_UNREQ;
              end else begin
                state_nxt = S_HIT;
              end
            end
            arp_pkg::FN_RESOLVE: begin
              if (in_lookup_ip == 32'd0) begin
                o_stb = 1'b1; o_st = arp_pkg::ST_INVALID;
              end else begin
                state_nxt = S_HIT;
              end
            end
            arp_pkg::FN_TICK: begin
              if (!armed_r) begin
                o_stb = 1'b1; o_st = arp_pkg::ST_RETX;
              end else begin
                armed_nxt = 1'b0; pend_nxt = 1'b0; n_nxt = '0;
                state_nxt = S_TICK;
              end
            end
            default: begin
              o_stb = 1'b1; o_st = arp_pkg::ST_INVALID;
            end
          endcase
        end
      end
      S_HIT: begin
        if (match) begin
          if (learn_r) state_nxt = S_LEARN;
          else state_nxt = S_RD;
        end else if (is_last) begin
          if (learn_r) begin
            o_stb = 1'b1; o_st = arp_pkg::ST_UNREQ; state_nxt = S_IDLE;
          end else begin
            idx_nxt = '0; state_nxt = S_EMPTY;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_LEARN: begin
        mark_ready = 1'b1;
        o_stb = 1'b1; o_st = arp_pkg::ST_LEARNED; state_nxt = S_IDLE;
      end
      S_RD: begin
        o_stb = 1'b1;
        if (ready_r[cur]) begin
          o_st = arp_pkg::ST_RESOLVED; o_found = rdata;
        end else begin
          o_st = arp_pkg::ST_PENDING;
        end
        state_nxt = S_IDLE;
      end
      S_EMPTY: begin
        if (!used_r[cur] || is_last) begin
          o_stb = 1'b1; o_op = arp_pkg::OP_REQ; o_mac = arp_pkg::MAC_BCAST;
          o_ip = key_r; armed_nxt = 1'b1; set_entry = 1'b1;
          if (used_r[cur]) begin
            flush = 1'b1; o_st = arp_pkg::ST_FLUSHED;
          end else begin
            o_st = arp_pkg::ST_NEWREQ;
          end
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_TICK: begin
        if (used_r[cur] && !ready_r[cur]) begin
          o_stb = 1'b1; o_st = arp_pkg::ST_RETX; o_op = arp_pkg::OP_REQ;
          o_mac = arp_pkg::MAC_BCAST; o_ip = addr_r[cur];
          pend_nxt = 1'b1; n_nxt = n_r + 1'b1;
          o_last = is_last;
        end else if (is_last && n_r == '0) begin
          o_stb = 1'b1; o_st = arp_pkg::ST_RETX;
        end else if (is_last) begin
          o_stb = 1'b1; o_st = arp_pkg::ST_RETX; o_last = 1'b1;
        end
        if (o_stb && !o_last) o_stb = 1'b1;
        if (is_last) begin
          if (pend_nxt) armed_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // A trailing empty slot after a last pending one would emit an extra
  // result, so lookahead flags the final pending request last and ends the scan.
  logic [TABLE_ENTRIES-1:0] pend_vec;
  logic        later_pend;
  always_comb begin
    pend_vec = used_r & ~ready_r;
    later_pend = 1'b0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (k > int'(idx_r) && pend_vec[k]) later_pend = 1'b1;
    end
  end

  logic fin_stb, fin_last;
  always_comb begin
    fin_stb = o_stb;
    fin_last = o_last;
    if (state_r == S_TICK) begin
      if (pend_vec[cur]) begin
        fin_last = !later_pend;
      end else begin
        fin_stb = is_last && (n_r == '0);
        fin_last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      armed_r <= 1'b0;
      pend_r <= 1'b0;
      n_r <= '0;
      used_r <= '0;
      ready_r <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r <= (state_r == S_TICK && pend_vec[cur] && !later_pend) ? S_IDLE : state_nxt;
      idx_r <= idx_nxt;
      armed_r <= (state_r == S_TICK && pend_vec[cur] && !later_pend) ? 1'b1 : armed_nxt;
      pend_r <= pend_nxt;
      n_r <= n_nxt;
      out_strobe <= fin_stb;
      if (flush) begin
        used_r <= TABLE_ENTRIES'(1);
        ready_r <= '0;
      end else if (set_entry) begin
        used_r[cur] <= 1'b1;
        ready_r[cur] <= 1'b0;
      end else if (mark_ready) begin
        ready_r[cur] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      key_r <= (in_func == arp_pkg::FN_HEADER) ? in_sender_ip : in_lookup_ip;
      smac_r <= in_sender_mac;
      learn_r <= (in_func == arp_pkg::FN_HEADER);
    end
    if (set_entry) begin
      addr_r[flush ? IW'(0) : cur] <= key_r;
    end
    out_status <= o_st;
    out_send_packet <= (o_op != arp_pkg::OP_NONE);
    out_send_opcode <= o_op;
    out_send_dest_mac <= o_mac;
    out_send_target_mac <= (o_op == arp_pkg::OP_REP) ? o_mac : 48'd0;
    out_send_target_ip <= o_ip;
    out_found_mac <= o_found;
    out_last <= fin_last;
  end
endmodule

module arp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]    wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]    rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
